// ===== design/mp22_pkg.sv =====
// ----------------------------------------------------------------------------
// mp22_pkg
// shared types and constants for the 2x2 stride-2 max pooling stream
// ----------------------------------------------------------------------------
package mp22_pkg;

    localparam int DATA_W           = 8;
    localparam int MAX_WIDTH_DEF    = 128;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int HEIGHT_LIMIT     = 128;
    localparam int ROW_W            = 7;
    localparam int HEIGHT_W         = 8;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [7:0] FRAME_WIDTH_RST   = 8'd16;
    localparam logic [7:0] FRAME_HEIGHT_RST  = 8'd16;
    localparam logic [4:0] CHANNEL_COUNT_RST = 5'd8;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        logic [7:0] frame_width;
        logic [7:0] frame_height;
        logic [4:0] channel_count;
    } t_cfg;

    // what the scan position means for the item arriving now
    typedef struct packed {
        logic in_range;
        logic start;
        logic emit;
        logic last;
    } t_pos_info;

endpackage

// ===== design/max_pool_2x2_hwc_stream.sv =====
// ----------------------------------------------------------------------------
// max_pool_2x2_hwc_stream
// 2x2 stride-2 max pooling over a streamed channel-interleaved feature map
// ----------------------------------------------------------------------------
// input channel: one signed 8-bit sample per item on i_sample, raster order
//   (rows, then columns, channels innermost), handshake i_sample_valid /
//   o_sample_ready
// output channel: one pooled maximum per completed window and channel on
//   o_pooled with o_frame_end high on the last one of a frame, handshake
//   o_pooled_valid / i_pooled_ready
// config: apb-style port, frame_width at 0x0, frame_height at 0x4,
//   channel_count at 0x8; any write restarts the frame, the block must be idle
// throughput: one item per clock, sustained while the output does not stall, set
//   by the line store with one read and one write port (read at accept, write as
//   the item leaves the window stage, forwarded when both hit the same entry)
// result path: the item that completes a window is registered in the window
//   stage, then its maximum goes to the result register that drives o_pooled
// reset: positions go to zero, registers to 16/16/8, pipeline empties; the
//   line store is not cleared, every window start writes its entry first
// stall: the result register holds; the window stage keeps working on items
//   that give no result and stops only when it has one to hand over
// ----------------------------------------------------------------------------
module max_pool_2x2_hwc_stream #(
    parameter int MAX_WIDTH    = mp22_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp22_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mp22_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mp22_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mp22_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // sample stream in
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  logic signed [7:0]               i_sample,
    // pooled stream out
    output logic                            o_pooled_valid,
    input  logic                            i_pooled_ready,
    output logic signed [7:0]               o_pooled,
    output logic                            o_frame_end
);
    import mp22_pkg::*;

    // one entry per half-column and channel
    localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg              cfg;
    logic              cfg_write;
    logic              accept;
    logic [ADDR_W-1:0] scan_addr;
    t_pos_info         scan_info;

    // an item is taken when both sides agree
    assign accept = i_sample_valid && o_sample_ready;

    mp22_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (cfg),
        .o_cfg_write (cfg_write)
    );

    // position counters run ahead of the data, so the store address is
    // ready before the item itself arrives
    mp22_scan #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cfg_write (cfg_write),
        .i_step      (accept),
        .o_addr      (scan_addr),
        .o_info      (scan_info)
    );

    mp22_core #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample       (i_sample),
        .i_addr         (scan_addr),
        .i_info         (scan_info),
        .o_ready        (o_sample_ready),
        .o_pooled_valid (o_pooled_valid),
        .i_pooled_ready (i_pooled_ready),
        .o_pooled       (o_pooled),
        .o_frame_end    (o_frame_end)
    );

endmodule

// ===== design/mp22_regs.sv =====
// ----------------------------------------------------------------------------
// mp22_regs
// apb-style configuration registers, frame restart pulse on every write
// ----------------------------------------------------------------------------
module mp22_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mp22_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mp22_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mp22_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output mp22_pkg::t_cfg                  o_cfg,
    output logic                            o_cfg_write
);
    import mp22_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= FRAME_WIDTH_RST;
            r_cfg.frame_height  <= FRAME_HEIGHT_RST;
            r_cfg.channel_count <= CHANNEL_COUNT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:   r_cfg.frame_width   <= pwdata[7:0];
                REG_FRAME_HEIGHT:  r_cfg.frame_height  <= pwdata[7:0];
                REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_FRAME_WIDTH:   prdata = APB_DATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(r_cfg.frame_height);
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(r_cfg.channel_count);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg       = r_cfg;
    assign o_cfg_write = wr_en;

endmodule

// ===== design/mp22_scan.sv =====
// ----------------------------------------------------------------------------
// mp22_scan
// raster position counters and line store address for the next item
// ----------------------------------------------------------------------------
module mp22_scan #(
    parameter int MAX_WIDTH    = mp22_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp22_pkg::MAX_CHANNELS_DEF,
    parameter int ADDR_W       = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mp22_pkg::t_cfg        i_cfg,
    input  logic                  i_cfg_write,
    input  logic                  i_step,
    output logic [ADDR_W-1:0]     o_addr,
    output mp22_pkg::t_pos_info   o_info
);
    import mp22_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CH_W-1:0]     r_ch, n_ch;

    logic [31:0]         w_ext, h_ext, c_ext;
    logic [WID_W-1:0]    w_eff, used_w;
    logic [HEIGHT_W-1:0] h_eff, used_h;
    logic [CNT_W-1:0]    c_eff;
    logic                row_odd, col_odd;

    // clamp the registers to the supported ranges
    always_comb begin
        w_ext = 32'(i_cfg.frame_width);
        h_ext = 32'(i_cfg.frame_height);
        c_ext = 32'(i_cfg.channel_count);
        if (w_ext < 32'd2)                   w_eff = WID_W'(2);
        else if (w_ext > 32'(MAX_WIDTH))     w_eff = WID_W'(MAX_WIDTH);
        else                                 w_eff = WID_W'(w_ext);
        if (h_ext < 32'd2)                   h_eff = HEIGHT_W'(2);
        else if (h_ext > 32'(HEIGHT_LIMIT))  h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        else                                 h_eff = HEIGHT_W'(h_ext);
        if (c_ext < 32'd1)                   c_eff = CNT_W'(1);
        else if (c_ext > 32'(MAX_CHANNELS))  c_eff = CNT_W'(MAX_CHANNELS);
        else                                 c_eff = CNT_W'(c_ext);
        used_w = {w_eff[WID_W-1:1], 1'b0};
        used_h = {h_eff[HEIGHT_W-1:1], 1'b0};
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ch  = r_ch;
        if (i_cfg_write) begin
            n_col = '0;
            n_row = '0;
            n_ch  = '0;
        end else if (i_step) begin
            if (CNT_W'(r_ch) + CNT_W'(1) >= c_eff) begin
                n_ch = '0;
                if (WID_W'(r_col) + WID_W'(1) >= w_eff) begin
                    n_col = '0;
                    if (HEIGHT_W'(r_row) + HEIGHT_W'(1) >= h_eff) begin
                        n_row = '0;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else begin
                n_ch = r_ch + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ch  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ch  <= n_ch;
        end
    end

    assign row_odd = r_row[0];
    assign col_odd = r_col[0];

    always_comb begin
        o_info.in_range = (WID_W'(r_col) < used_w) && (HEIGHT_W'(r_row) < used_h)
                          && (CNT_W'(r_ch) < c_eff);
        o_info.start    = !row_odd && !col_odd;
        o_info.emit     = row_odd && col_odd;
        o_info.last     = (HEIGHT_W'(r_row) == used_h - HEIGHT_W'(1))
                          && (WID_W'(r_col) == used_w - WID_W'(1))
                          && (CNT_W'(r_ch) == c_eff - CNT_W'(1));
    end

    // half-column major, channel minor
    assign o_addr = ADDR_W'(32'(r_col >> 1) * 32'(MAX_CHANNELS) + 32'(r_ch));

endmodule

// ===== design/mp22_core.sv =====
// ----------------------------------------------------------------------------
// mp22_core
// window stage with line store, forwarding and the result register
// ----------------------------------------------------------------------------
module mp22_core #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  mp22_pkg::t_sample     i_sample,
    input  logic [ADDR_W-1:0]     i_addr,
    input  mp22_pkg::t_pos_info   i_info,
    output logic                  o_ready,
    output logic                  o_pooled_valid,
    input  logic                  i_pooled_ready,
    output mp22_pkg::t_sample     o_pooled,
    output logic                  o_frame_end
);
    import mp22_pkg::*;

    t_sample             mem [DEPTH];

    logic                r_a_valid;
    t_sample             r_a_sample;
    logic [ADDR_W-1:0]   r_a_addr;
    t_pos_info           r_a_info;
    t_sample             r_rd_data;
    logic                r_fwd_hit;
    t_sample             r_fwd_data;
    logic                r_out_valid;
    t_sample             r_out_pooled;
    logic                r_out_frame_end;

    t_sample             a_old, a_new;
    logic                a_we, a_emit, a_advance, fwd_hit;

    always_comb begin
        a_old     = r_fwd_hit ? r_fwd_data : r_rd_data;
        a_new     = (r_a_info.start || (r_a_sample > a_old)) ? r_a_sample : a_old;
        a_we      = r_a_info.in_range;
        a_emit    = r_a_info.in_range && r_a_info.emit;
        a_advance = r_a_valid && (!a_emit || !r_out_valid || i_pooled_ready);
        fwd_hit   = a_advance && a_we && (r_a_addr == i_addr);
    end

    assign o_ready = !r_a_valid || a_advance;

    // line store, read-before-write, read data registered
    always_ff @(posedge i_clk) begin
        if (a_advance && a_we) begin
            mem[r_a_addr] <= a_new;
        end
        if (i_accept) begin
            r_rd_data <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_sample <= i_sample;
            r_a_addr   <= i_addr;
            r_a_info   <= i_info;
            r_fwd_data <= a_new;
        end
        if (a_advance && a_emit) begin
            r_out_pooled    <= a_new;
            r_out_frame_end <= r_a_info.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_valid <= 1'b1;
                r_fwd_hit <= fwd_hit;
            end else if (a_advance) begin
                r_a_valid <= 1'b0;
            end
            if (a_advance && a_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pooled_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pooled_valid = r_out_valid;
    assign o_pooled       = r_out_pooled;
    assign o_frame_end    = r_out_frame_end;

endmodule

// ===== design/mp22_checker.sv =====
// ----------------------------------------------------------------------------
// mp22_checker
// port-level assertions for the max pooling stream, bound to the top level
// ----------------------------------------------------------------------------
module mp22_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [mp22_pkg::APB_ADDR_W-1:0] paddr,
    input logic [mp22_pkg::APB_DATA_W-1:0] pwdata,
    input logic [mp22_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            i_sample_valid,
    input logic                            o_sample_ready,
    input logic                            o_pooled_valid,
    input logic                            i_pooled_ready
);
    import mp22_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pooled_valid && !i_pooled_ready |=> o_pooled_valid)
        else $error("pooled item dropped while stalled");

    // a new result rises only after an accepted input item
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pooled_valid) |-> $past(i_sample_valid && o_sample_ready, 2))
        else $error("pooled item without a matching input item");

    // an empty result register never blocks the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pooled_valid |-> o_sample_ready)
        else $error("input stalled with nothing pending downstream");

    // width register reads back what was written
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[3:2] == REG_FRAME_WIDTH) |=>
        (!(psel && !pwrite && paddr[3:2] == REG_FRAME_WIDTH)
         || prdata[7:0] == $past(pwdata[7:0])))
        else $error("frame width readback mismatch");

endmodule

bind max_pool_2x2_hwc_stream mp22_checker u_mp22_checker (.*);

// ===== bench/max_pool_2x2_hwc_stream_test.sv =====
// ----------------------------------------------------------------------------
// max_pool_2x2_hwc_stream_test
// self-checking bench for the streamed 2x2 stride-2 max pooling block
// ----------------------------------------------------------------------------
// every accepted sample goes through a cycle-free model of the window scan,
// which queues the pooled maximum and frame-end flag it should produce; every
// pooled item from the block is matched in order against that queue. frames
// are reshaped over the apb-style port between phases, including clamped and
// odd sizes, while both handshakes idle at random, with a long output hold-off
// that backs the pipeline up into the input
// ----------------------------------------------------------------------------
module max_pool_2x2_hwc_stream_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mp22_pkg::*;

    localparam int          CLK_PERIOD    = 12;
    localparam int          RANDOM_ITEMS  = 1560;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASE_CAP     = 256;
    localparam int          STORE_DEPTH   = (MAX_WIDTH_DEF / 2) * MAX_CHANNELS_DEF;
    // register slot with no register behind it, a write still restarts the frame
    localparam logic [1:0]  REG_SPARE     = 2'd3;

    typedef struct packed {
        t_sample pooled;
        logic    frame_end;
    } t_pooled_item;

    // ------------------------------------------------------------------------
    // window scan model and in-order result store
    // ------------------------------------------------------------------------
    class pool_checker;
        t_sample        line_max [STORE_DEPTH];
        int unsigned    col, row, chan;
        logic [7:0]     width_reg, height_reg;
        logic [4:0]     chan_reg;
        t_pooled_item   pooled_due [$];
        int             errors;

        function new();
            foreach (line_max[i]) line_max[i] = '0;
            col        = 0;
            row        = 0;
            chan       = 0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            chan_reg   = CHANNEL_COUNT_RST;
            errors     = 0;
        endfunction

        // register values as the block actually uses them
        function int unsigned act_width();
            if (width_reg < 2) return 2;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return 32'(width_reg);
        endfunction

        function int unsigned act_height();
            if (height_reg < 2) return 2;
            if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
            return 32'(height_reg);
        endfunction

        function int unsigned act_chans();
            if (chan_reg < 1) return 1;
            if (chan_reg > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
            return 32'(chan_reg);
        endfunction

        function int unsigned frame_length();
            return act_width() * act_height() * act_chans();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_FRAME_WIDTH:   width_reg  = data[7:0];
                REG_FRAME_HEIGHT:  height_reg = data[7:0];
                REG_CHANNEL_COUNT: chan_reg   = data[4:0];
                default: ;
            endcase
            col  = 0;
            row  = 0;
            chan = 0;
        endfunction

        function void take_sample(t_sample s);
            int unsigned  w    = act_width();
            int unsigned  h    = act_height();
            int unsigned  c    = act_chans();
            int unsigned  uw   = w & ~1;
            int unsigned  uh   = h & ~1;
            int unsigned  slot;
            bit           odd_row, odd_col;
            t_pooled_item e;
            if (col < uw && row < uh && chan < c) begin
                slot    = (col >> 1) * MAX_CHANNELS_DEF + chan;
                odd_row = (row & 1) != 0;
                odd_col = (col & 1) != 0;
                if (!odd_row && !odd_col) begin
                    line_max[slot] = s;
                end else if (s > line_max[slot]) begin
                    line_max[slot] = s;
                end
                if (odd_row && odd_col) begin
                    e.pooled    = line_max[slot];
                    e.frame_end = (row == uh - 1) && (col == uw - 1) && (chan == c - 1);
                    pooled_due.push_back(e);
                end
            end
            chan++;
            if (chan >= c) begin
                chan = 0;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                    if (row >= h) row = 0;
                end
            end
        endfunction

        function void match_pooled(t_sample got, logic got_end);
            t_pooled_item e;
            if (pooled_due.size() == 0) begin
                $error("pooled: no item pending, got %0d (frame_end %0b)", got, got_end);
                errors++;
                return;
            end
            e = pooled_due.pop_front();
            if (got !== e.pooled) begin
                $error("pooled: expected %0d, got %0d", e.pooled, got);
                errors++;
            end
            if (got_end !== e.frame_end) begin
                $error("frame_end: expected %0b, got %0b", e.frame_end, got_end);
                errors++;
            end
        endfunction

        function int outstanding();
            return pooled_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_sample_valid = 1'b0;
    logic                  o_sample_ready;
    logic signed [7:0]     i_sample       = '0;
    logic                  o_pooled_valid;
    logic                  i_pooled_ready = 1'b0;
    logic signed [7:0]     o_pooled;
    logic                  o_frame_end;

    // stimulus control, written only by the main sequence
    bit                    quiet          = 1'b0;
    int                    hold_requests  = 0;

    // receiver hold-off bookkeeping, owned by the ready process
    int                    hold_served    = 0;
    int                    hold_left      = 0;

    pool_checker           board          = new();

    // directed items: 2x2 single-channel frames back to back, then a 3x3 frame
    // whose last column and row must be dropped
    logic [7:0]            edge_items [0:24] = '{
        8'h7f, 8'h80, 8'h80, 8'h80,     // window start holds the maximum
        8'h80, 8'h80, 8'h80, 8'h80,     // start overwrites the stale 127
        8'h80, 8'h80, 8'h80, 8'h7f,     // maximum arrives last
        8'h00, 8'h05, 8'hfd, 8'h01,     // signed compare, 0xfd is negative
        8'hf6, 8'hec, 8'h7f,
        8'he2, 8'hd8, 8'h7f,
        8'h7f, 8'h7f, 8'h7f
    };

    max_pool_2x2_hwc_stream dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_pooled_valid (o_pooled_valid),
        .i_pooled_ready (i_pooled_ready),
        .o_pooled       (o_pooled),
        .o_frame_end    (o_frame_end)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // both handshakes observed at the same edge, samples noted before results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_sample_valid && o_sample_ready) board.take_sample(i_sample);
            if (o_pooled_valid && i_pooled_ready) board.match_pooled(o_pooled, o_frame_end);
        end
    end

    // receiver: random back-pressure, a counted hold-off on request, none when quiet
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served    <= hold_requests;
            hold_left      <= HOLD_CYCLES;
            i_pooled_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            i_pooled_ready <= 1'b0;
        end else if (quiet) begin
            i_pooled_ready <= 1'b1;
        end else begin
            i_pooled_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // ------------------------------------------------------------------------
    // drivers, each entered just after a rising edge
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // all three registers in a rotated order, junk above each field
    task automatic set_frame(input logic [7:0] w, input logic [7:0] h, input logic [4:0] c);
        logic [1:0]  reg_order [3] = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CHANNEL_COUNT};
        int          first = $urandom_range(0, 2);
        logic [31:0] data;
        if ($urandom_range(0, 3) == 0) apb_write(REG_SPARE, $urandom());
        for (int k = 0; k < 3; k++) begin
            data = $urandom();
            case (reg_order[(first + k) % 3])
                REG_FRAME_WIDTH:   data[7:0] = w;
                REG_FRAME_HEIGHT:  data[7:0] = h;
                REG_CHANNEL_COUNT: data[4:0] = c;
                default: ;
            endcase
            apb_write(reg_order[(first + k) % 3], data);
        end
    endtask

    // valid stays up between items unless a gap is drawn
    task automatic send_sample(input logic [7:0] v);
        int gap = 0;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 37) gap++;
        end
        if (gap != 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [7:0] v;
        for (int n = 0; n < count; n++) begin
            v = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 8'h7f : 8'h80;
            send_sample(v);
        end
    endtask

    // sender pauses until every pooled item is back and the pipeline is empty
    task automatic wait_drained();
        i_sample_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int         phase;
        int         choice;
        int         total;
        int         random_items;
        bit         broken;
        logic [7:0] w_raw, h_raw;
        logic [4:0] c_raw;

        phase        = 0;
        random_items = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, two rows; output held off while the input streams on
        quiet         <= 1'b1;
        hold_requests <= hold_requests + 1;
        send_random(2 * FRAME_WIDTH_RST * CHANNEL_COUNT_RST);
        wait_drained();
        quiet <= 1'b0;

        // directed corners
        set_frame(8'd2, 8'd2, 5'd1);
        for (int i = 0; i < 16; i++) send_sample(edge_items[i]);
        wait_drained();
        set_frame(8'd3, 8'd3, 5'd1);
        for (int i = 16; i < 25; i++) send_sample(edge_items[i]);
        wait_drained();

        // random phases: extremes and clamped sizes first, then small frames mixed with them
        while (random_items < RANDOM_ITEMS) begin
            phase++;
            choice = (phase <= 7) ? phase : $urandom_range(1, 14);
            case (choice)
                1: begin
                    w_raw = 8'd128; h_raw = 8'd2; c_raw = 5'($urandom_range(1, 2));
                end
                2: begin
                    w_raw = 8'd2; h_raw = 8'd128; c_raw = 5'd1;
                end
                3: begin
                    w_raw = 8'($urandom_range(2, 4)); h_raw = 8'd2; c_raw = 5'd16;
                end
                4: begin
                    // below range, acts as the smallest frame
                    w_raw = 8'($urandom_range(0, 1)); h_raw = 8'($urandom_range(0, 1));
                    c_raw = 5'd0;
                end
                5: begin
                    w_raw = 8'($urandom_range(129, 255)); h_raw = 8'($urandom_range(0, 3));
                    c_raw = 5'd1;
                end
                6: begin
                    w_raw = 8'($urandom_range(2, 3)); h_raw = 8'($urandom_range(2, 3));
                    c_raw = 5'($urandom_range(17, 31));
                end
                7: begin
                    w_raw = 8'($urandom_range(0, 1)); h_raw = 8'($urandom_range(129, 255));
                    c_raw = 5'd1;
                end
                default: begin
                    w_raw = 8'($urandom_range(2, 9)); h_raw = 8'($urandom_range(2, 9));
                    c_raw = 5'($urandom_range(1, 4));
                end
            endcase
            set_frame(w_raw, h_raw, c_raw);
            // a stretch with no idling on either side
            quiet <= (phase == 2 || phase == 3);

            total = board.frame_length() * $urandom_range(1, 3);
            if (total > PHASE_CAP) total = PHASE_CAP;
            broken = ($urandom_range(0, 99) < 15) && (total > 1);
            if (broken) total = $urandom_range(1, total - 1);
            send_random(total);
            random_items += total;

            // cut frame, then a restart through the empty register slot
            if (broken && $urandom_range(0, 1)) begin
                wait_drained();
                apb_write(REG_SPARE, $urandom());
                total = board.frame_length();
                if (total > PHASE_CAP) total = PHASE_CAP;
                send_random(total);
                random_items += total;
            end
            wait_drained();
        end
        quiet <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mp22_pkg.sv
design/mp22_regs.sv
design/mp22_scan.sv
design/mp22_core.sv
design/max_pool_2x2_hwc_stream.sv
design/mp22_checker.sv
bench/max_pool_2x2_hwc_stream_test.sv
